// ----- sv/two_level_bitmap_intersect_top_assert.svh -----
// assertion macros for the two-level bitmap intersect block
`ifndef TWO_LEVEL_BITMAP_INTERSECT_TOP_ASSERT_SVH
`define TWO_LEVEL_BITMAP_INTERSECT_TOP_ASSERT_SVH
`ifndef SYNTH
`define TLBM_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define TLBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLBM_ASSERT_HOLDS(lbl, cond, msg)
`define TLBM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/tlbm_pkg.sv -----
// shared types, codes and helpers of the two-level bitmap intersect block
package tlbm_pkg;

  localparam int unsigned WORD_W = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_FETCH  = 2'd2,
    OP_START  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_INS_WR,
    ST_CL_SUM,
    ST_CL_LOAD,
    ST_CL_PICK,
    ST_CL_WRD,
    ST_CL_WWR,
    ST_CL_ROW,
    ST_F_SUM,
    ST_F_SCHK,
    ST_F_WRD,
    ST_F_WCHK,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic init_busy;
    logic idle;
  } back_status_t;

  function automatic logic [5:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage

// ----- sv/tlbm_front.sv -----
// front end: accepts beats, splits the doc id into word, group and bit
module tlbm_front
  import tlbm_pkg::*;
#(
  parameter int unsigned DOC_ID_BITS = 20,
  parameter int unsigned GROUP_WORDS = 4,
  parameter int unsigned DATA_W      = 24,
  parameter int unsigned ENT_W       = 28
) (
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [DATA_W-1:0] s_data_i,
  input  logic [1:0]        s_user_i,
  input  logic              full_i,
  input  logic              hold_i,
  output logic              push_o,
  output logic [ENT_W-1:0]  push_data_o
);

  localparam int unsigned WORD_BITS = DOC_ID_BITS - 6;
  localparam int unsigned NWORDS    = 1 << WORD_BITS;
  localparam int unsigned NGROUPS   = (NWORDS + GROUP_WORDS - 1) / GROUP_WORDS;
  localparam int unsigned NSUMW     = (NGROUPS + 63) / 64;
  localparam int unsigned ROW_BITS  = (NSUMW > 1) ? $clog2(NSUMW) : 1;
  localparam int unsigned GRP_BITS  = ROW_BITS + 6;
  localparam int unsigned LG        = (GROUP_WORDS > 1) ? $clog2(GROUP_WORDS) : 0;
  localparam int unsigned SH        = WORD_BITS + LG;
  localparam int unsigned RECIP     = ((1 << SH) + GROUP_WORDS - 1) / GROUP_WORDS;
  localparam int unsigned PW        = 2 * WORD_BITS + 2;

  logic [WORD_BITS-1:0] word;
  logic [PW-1:0]        prod;
  logic [GRP_BITS-1:0]  grp;
  op_e                  op;

  // group = word / GROUP_WORDS through a rounded-up reciprocal, exact for all words
  assign word = s_data_i[DOC_ID_BITS-1:6];
  assign prod = PW'(word) * PW'(RECIP);
  assign grp  = GRP_BITS'(prod >> SH);
  assign op   = op_e'(s_user_i);

  assign s_ready_o   = !full_i && !hold_i;
  assign push_o      = s_valid_i && s_ready_o;
  assign push_data_o = {op, word, grp, s_data_i[5:0]};

endmodule

// ----- sv/tlbm_fifo.sv -----
// small queue between front end and engine
module tlbm_fifo #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop) rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ----- sv/tlbm_back.sv -----
// engine: bitmap memories, insert, close-term walk and fetch scan
module tlbm_back
  import tlbm_pkg::*;
#(
  parameter int unsigned DOC_ID_BITS = 20,
  parameter int unsigned GROUP_WORDS = 4,
  parameter int unsigned ENT_W       = 28
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  logic [ENT_W-1:0]       q_data_i,
  output logic                   q_pop_o,
  output back_status_t           status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DOC_ID_BITS-1:0] out_id_o,
  output logic                   out_found_o
);

  localparam int unsigned WORD_BITS = DOC_ID_BITS - 6;
  localparam int unsigned NWORDS    = 1 << WORD_BITS;
  localparam int unsigned NGROUPS   = (NWORDS + GROUP_WORDS - 1) / GROUP_WORDS;
  localparam int unsigned NSUMW     = (NGROUPS + 63) / 64;
  localparam int unsigned ROW_BITS  = (NSUMW > 1) ? $clog2(NSUMW) : 1;
  localparam int unsigned NSUMR     = 1 << ROW_BITS;
  localparam int unsigned GRP_BITS  = ROW_BITS + 6;
  localparam int unsigned K_BITS    = (GROUP_WORDS > 1) ? $clog2(GROUP_WORDS) : 1;
  localparam int unsigned BP_W      = GRP_BITS + 5;
  localparam logic [K_BITS-1:0]   K_LAST   = K_BITS'(GROUP_WORDS - 1);
  localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(NSUMW - 1);

  // memories
  logic [WORD_W-1:0] term_mem [NWORDS];
  logic [WORD_W-1:0] acc_mem  [NWORDS];
  logic [WORD_W-1:0] tsum_mem [NSUMR];
  logic [WORD_W-1:0] asum_mem [NSUMR];
  logic [NSUMR-1:0]  tsv_q, asv_q;
  logic [WORD_W-1:0] term_rd_q, acc_rd_q, tsum_rd_q, asum_rd_q;
  logic              tsv_rd_q, asv_rd_q;

  logic [WORD_BITS-1:0] word_raddr, word_waddr;
  logic [ROW_BITS-1:0]  sum_raddr, sum_waddr;
  logic                 term_we, acc_we, tsum_we, asum_we, asv_clr;
  logic [WORD_W-1:0]    term_wdata, acc_wdata, tsum_wdata, asum_wdata;

  back_state_e state_q, state_d;
  logic [WORD_BITS-1:0] init_cnt_q, init_cnt_d;
  logic                 have_first_q, have_first_d;
  logic [WORD_BITS-1:0] cw_q, cw_d;
  logic [GRP_BITS-1:0]  cg_q, cg_d;
  logic [K_BITS-1:0]    ck_q, ck_d;
  logic [5:0]           cb_q, cb_d;
  logic                 cend_q, cend_d;
  logic [WORD_BITS-1:0] it_w_q, it_w_d;
  logic [GRP_BITS-1:0]  it_g_q, it_g_d;
  logic [5:0]           it_b_q, it_b_d;
  logic [ROW_BITS-1:0]  row_q, row_d;
  logic [WORD_W-1:0]    pend_q, pend_d, abits_q, abits_d, nacc_q, nacc_d;
  logic [5:0]           gi_q, gi_d;
  logic [WORD_BITS-1:0] ww_q, ww_d;
  logic [K_BITS-1:0]    wk_q, wk_d;
  logic                 any_q, any_d;
  logic [DOC_ID_BITS-1:0] res_id_q, res_id_d, oid_q;
  logic                 res_found_q, res_found_d, ofound_q, ov_q, out_load;

  op_e                  h_op;
  logic [WORD_BITS-1:0] h_w;
  logic [GRP_BITS-1:0]  h_g;
  logic [5:0]           h_b;

  logic [WORD_W-1:0]    trow, arow, anded, fmask;
  logic                 any_new;
  logic [5:0]           lb, pick;
  logic [BP_W-1:0]      base_prod;
  logic                 nx_end, nx_grp;
  logic [WORD_BITS-1:0] nx_w;
  logic [K_BITS-1:0]    nx_k;
  logic [GRP_BITS-1:0]  nx_g;
  logic [WORD_BITS:0]   ga_sum;

  assign h_op = op_e'(q_data_i[ENT_W-1 -: 2]);
  assign h_w  = q_data_i[GRP_BITS+6 +: WORD_BITS];
  assign h_g  = q_data_i[6 +: GRP_BITS];
  assign h_b  = q_data_i[5:0];

  assign trow      = tsv_rd_q ? tsum_rd_q : '0;
  assign arow      = asv_rd_q ? asum_rd_q : '0;
  assign anded     = acc_rd_q & term_rd_q;
  assign fmask     = acc_rd_q & ({WORD_W{1'b1}} << cb_q);
  assign lb        = lowest_set(fmask);
  assign pick      = lowest_set(pend_q);
  assign base_prod = BP_W'({row_q, pick}) * BP_W'(GROUP_WORDS);

  // cursor step to the next word
  assign nx_end = &cw_q;
  assign nx_grp = (ck_q == K_LAST);
  assign nx_w   = cw_q + 1'b1;
  assign nx_k   = nx_grp ? '0 : ck_q + 1'b1;
  assign nx_g   = nx_grp ? cg_q + 1'b1 : cg_q;
  // cursor jump to the first word of the next group
  assign ga_sum = (WORD_BITS+1)'(cw_q) + (WORD_BITS+1)'(GROUP_WORDS)
                - (WORD_BITS+1)'(ck_q);

  always_comb begin
    state_d      = state_q;
    init_cnt_d   = init_cnt_q;
    have_first_d = have_first_q;
    cw_d = cw_q; cg_d = cg_q; ck_d = ck_q; cb_d = cb_q; cend_d = cend_q;
    it_w_d = it_w_q; it_g_d = it_g_q; it_b_d = it_b_q;
    row_d = row_q; pend_d = pend_q; abits_d = abits_q; nacc_d = nacc_q;
    gi_d = gi_q; ww_d = ww_q; wk_d = wk_q; any_d = any_q;
    res_id_d = res_id_q; res_found_d = res_found_q;
    any_new    = any_q;
    q_pop_o    = 1'b0;
    word_raddr = cw_q;
    sum_raddr  = cg_q[GRP_BITS-1:6];
    word_waddr = ww_q;
    sum_waddr  = row_q;
    term_we    = 1'b0;
    term_wdata = '0;
    acc_we     = 1'b0;
    acc_wdata  = anded;
    tsum_we    = 1'b0;
    tsum_wdata = '0;
    asum_we    = 1'b0;
    asum_wdata = nacc_q;
    asv_clr    = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        // clearing pass over the term words
        term_we    = 1'b1;
        word_waddr = init_cnt_q;
        init_cnt_d = init_cnt_q + 1'b1;
        if (&init_cnt_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          it_w_d  = h_w;
          it_g_d  = h_g;
          it_b_d  = h_b;
          unique case (h_op)
            OP_INSERT: begin
              word_raddr = h_w;
              sum_raddr  = h_g[GRP_BITS-1:6];
              state_d    = ST_INS_WR;
            end
            OP_CLOSE: begin
              row_d     = '0;
              sum_raddr = '0;
              state_d   = ST_CL_LOAD;
            end
            OP_FETCH: begin
              if (cend_q) begin
                res_id_d    = '0;
                res_found_d = 1'b0;
                state_d     = ST_OUT;
              end else begin
                state_d = ST_F_SCHK;
              end
            end
            OP_START: begin
              asv_clr      = 1'b1;
              have_first_d = 1'b0;
              cw_d = '0; cg_d = '0; ck_d = '0; cb_d = '0; cend_d = 1'b0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_WR: begin
        term_we    = 1'b1;
        word_waddr = it_w_q;
        term_wdata = term_rd_q | (64'b1 << it_b_q);
        tsum_we    = 1'b1;
        sum_waddr  = it_g_q[GRP_BITS-1:6];
        tsum_wdata = trow | (64'b1 << it_g_q[5:0]);
        state_d    = ST_IDLE;
      end
      ST_CL_SUM: begin
        sum_raddr = row_q;
        state_d   = ST_CL_LOAD;
      end
      ST_CL_LOAD: begin
        pend_d  = trow;
        abits_d = arow;
        nacc_d  = have_first_q ? '0 : trow;
        state_d = ST_CL_PICK;
      end
      ST_CL_PICK: begin
        if (pend_q == '0) begin
          state_d = ST_CL_ROW;
        end else begin
          gi_d    = pick;
          pend_d  = pend_q & (pend_q - 1'b1);
          ww_d    = base_prod[WORD_BITS-1:0];
          wk_d    = '0;
          any_d   = 1'b0;
          state_d = ST_CL_WRD;
        end
      end
      ST_CL_WRD: begin
        word_raddr = ww_q;
        state_d    = ST_CL_WWR;
      end
      ST_CL_WWR: begin
        term_we = 1'b1;
        if (!have_first_q) begin
          acc_we    = 1'b1;
          acc_wdata = term_rd_q;
        end else if (abits_q[gi_q]) begin
          acc_we  = 1'b1;
          any_new = any_q | (|anded);
        end
        any_d = any_new;
        if ((wk_q == K_LAST) || (&ww_q)) begin
          if (have_first_q) nacc_d[gi_q] = any_new;
          state_d = ST_CL_PICK;
        end else begin
          ww_d    = ww_q + 1'b1;
          wk_d    = wk_q + 1'b1;
          state_d = ST_CL_WRD;
        end
      end
      ST_CL_ROW: begin
        asum_we = 1'b1;
        tsum_we = 1'b1;
        if (row_q == ROW_LAST) begin
          have_first_d = 1'b1;
          cw_d = '0; cg_d = '0; ck_d = '0; cb_d = '0; cend_d = 1'b0;
          state_d = ST_IDLE;
        end else begin
          row_d   = row_q + 1'b1;
          state_d = ST_CL_SUM;
        end
      end
      ST_F_SUM: begin
        state_d = ST_F_SCHK;
      end
      ST_F_SCHK: begin
        if (asv_rd_q && asum_rd_q[cg_q[5:0]]) begin
          state_d = ST_F_WCHK;
        end else if (ga_sum[WORD_BITS]) begin
          cend_d      = 1'b1;
          res_id_d    = '0;
          res_found_d = 1'b0;
          state_d     = ST_OUT;
        end else begin
          cw_d    = ga_sum[WORD_BITS-1:0];
          cg_d    = cg_q + 1'b1;
          ck_d    = '0;
          cb_d    = '0;
          state_d = ST_F_SUM;
        end
      end
      ST_F_WRD: begin
        state_d = ST_F_WCHK;
      end
      ST_F_WCHK: begin
        if (fmask != '0) begin
          res_id_d    = {cw_q, lb};
          res_found_d = 1'b1;
          state_d     = ST_OUT;
          if (lb != 6'd63) begin
            cb_d = lb + 6'd1;
          end else begin
            cb_d = '0;
            if (nx_end) begin
              cend_d = 1'b1;
            end else begin
              cw_d = nx_w; ck_d = nx_k; cg_d = nx_g;
            end
          end
        end else begin
          cb_d = '0;
          if (nx_end) begin
            cend_d      = 1'b1;
            res_id_d    = '0;
            res_found_d = 1'b0;
            state_d     = ST_OUT;
          end else begin
            cw_d = nx_w; ck_d = nx_k; cg_d = nx_g;
            state_d = nx_grp ? ST_F_SUM : ST_F_WRD;
          end
        end
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      init_cnt_q   <= '0;
      have_first_q <= 1'b0;
      cw_q         <= '0;
      cg_q         <= '0;
      ck_q         <= '0;
      cb_q         <= '0;
      cend_q       <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_cnt_q   <= init_cnt_d;
      have_first_q <= have_first_d;
      cw_q         <= cw_d;
      cg_q         <= cg_d;
      ck_q         <= ck_d;
      cb_q         <= cb_d;
      cend_q       <= cend_d;
      if (out_load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    it_w_q      <= it_w_d;
    it_g_q      <= it_g_d;
    it_b_q      <= it_b_d;
    row_q       <= row_d;
    pend_q      <= pend_d;
    abits_q     <= abits_d;
    nacc_q      <= nacc_d;
    gi_q        <= gi_d;
    ww_q        <= ww_d;
    wk_q        <= wk_d;
    any_q       <= any_d;
    res_id_q    <= res_id_d;
    res_found_q <= res_found_d;
    if (out_load) begin
      oid_q    <= res_id_q;
      ofound_q <= res_found_q;
    end
  end

  // word memories
  always_ff @(posedge clk_i) begin
    if (term_we) term_mem[word_waddr] <= term_wdata;
    term_rd_q <= term_mem[word_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[word_waddr] <= acc_wdata;
    acc_rd_q <= acc_mem[word_raddr];
  end

  // summary memories, rows read as zero until written
  always_ff @(posedge clk_i) begin
    if (tsum_we) tsum_mem[sum_waddr] <= tsum_wdata;
    if (asum_we) asum_mem[sum_waddr] <= asum_wdata;
    tsum_rd_q <= tsum_mem[sum_raddr];
    asum_rd_q <= asum_mem[sum_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsv_q    <= '0;
      asv_q    <= '0;
      tsv_rd_q <= 1'b0;
      asv_rd_q <= 1'b0;
    end else begin
      if (tsum_we) tsv_q[sum_waddr] <= 1'b1;
      if (asv_clr) asv_q <= '0;
      else if (asum_we) asv_q[sum_waddr] <= 1'b1;
      tsv_rd_q <= tsv_q[sum_raddr];
      asv_rd_q <= asv_q[sum_raddr];
    end
  end

  assign status_o.init_busy = (state_q == ST_INIT);
  assign status_o.idle      = (state_q == ST_IDLE);
  assign out_valid_o        = ov_q;
  assign out_id_o           = oid_q;
  assign out_found_o        = ofound_q;

endmodule

// ----- sv/two_level_bitmap_intersect_top.sv -----
// top level of the two-level bitmap posting-list intersect block
//
// input stream: s_axis_tuser carries the op (insert, close term, fetch, start query),
// s_axis_tdata the doc id. output stream: one beat per fetch, m_axis_tdata the doc id,
// m_axis_tuser the found flag (0 with id 0 marks the end of the result list).
// a front end takes beats into a two-entry queue; the engine works one op at a time.
// after reset the engine clears the 2**(DOC_ID_BITS-6) term words (16384 at the default),
// one word a cycle; no input beat is taken during that pass.
// insert: a read-modify-write of the term word and summary row in the engine.
// close term: walks each summary row (64-group rows) and, for each group set in the
// term summary, the words of that group.
// fetch: a summary read and check per group reached and a word read and check per word
// scanned, bounded by the summary and word memory read ports, plus taking the beat and
// loading the output register.
// the result sits in an output register; while the receiver stalls the engine holds
// its next result and the queue keeps taking input beats until full.
module two_level_bitmap_intersect_top
  import tlbm_pkg::*;
#(
  parameter int unsigned DOC_ID_BITS = 20,
  parameter int unsigned GROUP_WORDS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((DOC_ID_BITS+7)/8)*8-1:0]     s_axis_tdata,  // doc_id
  input  logic [1:0]                           s_axis_tuser,  // op
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((DOC_ID_BITS+7)/8)*8-1:0]     m_axis_tdata,  // result_doc_id
  output logic                                 m_axis_tuser   // found
);

`include "two_level_bitmap_intersect_top_assert.svh"

  localparam int unsigned DATA_W    = ((DOC_ID_BITS + 7) / 8) * 8;
  localparam int unsigned WORD_BITS = DOC_ID_BITS - 6;
  localparam int unsigned NWORDS    = 1 << WORD_BITS;
  localparam int unsigned NGROUPS   = (NWORDS + GROUP_WORDS - 1) / GROUP_WORDS;
  localparam int unsigned NSUMW     = (NGROUPS + 63) / 64;
  localparam int unsigned ROW_BITS  = (NSUMW > 1) ? $clog2(NSUMW) : 1;
  localparam int unsigned GRP_BITS  = ROW_BITS + 6;
  localparam int unsigned ENT_W     = 2 + WORD_BITS + GRP_BITS + 6;

  logic                   push, full, empty, pop;
  logic [ENT_W-1:0]       push_data, head;
  back_status_t           st;
  logic [DOC_ID_BITS-1:0] out_id;
  logic                   out_found;

  tlbm_front #(
    .DOC_ID_BITS(DOC_ID_BITS),
    .GROUP_WORDS(GROUP_WORDS),
    .DATA_W     (DATA_W),
    .ENT_W      (ENT_W)
  ) u_front (
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .full_i     (full),
    .hold_i     (st.init_busy),
    .push_o     (push),
    .push_data_o(push_data)
  );

  tlbm_fifo #(
    .WIDTH(ENT_W),
    .DEPTH(2)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (pop),
    .data_o (head),
    .empty_o(empty)
  );

  tlbm_back #(
    .DOC_ID_BITS(DOC_ID_BITS),
    .GROUP_WORDS(GROUP_WORDS),
    .ENT_W      (ENT_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (!empty),
    .q_data_i   (head),
    .q_pop_o    (pop),
    .status_o   (st),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_id_o   (out_id),
    .out_found_o(out_found)
  );

  assign m_axis_tdata = DATA_W'(out_id);
  assign m_axis_tuser = out_found;

  `TLBM_ASSERT_HOLDS(a_end_has_zero_id, !(m_axis_tvalid && !m_axis_tuser) || (m_axis_tdata == '0), "end-of-list beat carries a nonzero id")
  `TLBM_ASSERT_HOLDS(a_pop_only_idle, !pop || st.idle, "queue popped while engine busy")
  `TLBM_ASSERT_HOLDS(a_no_take_in_init, !(st.init_busy && s_axis_tready), "input taken during clearing pass")
  `TLBM_ASSERT_NEXT(a_start_one_cycle, pop && (op_e'(head[ENT_W-1 -: 2]) == OP_START), st.idle, "start query left the engine busy")

endmodule
